>>> rtl/u8d_pkg.sv
// Package: shared types and constants for the UTF-8 stream decoder.
`timescale 1ns / 1ps
package u8d_pkg;

  localparam int unsigned CpW   = 21;
  localparam int unsigned ByteW = 8;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_LEAD  = 3'd1,
    ST_BAD_CONT  = 3'd2,
    ST_SURROGATE = 3'd3,
    ST_TRUNC     = 3'd4
  } status_e;

  // Lead byte boundaries
  localparam logic [ByteW-1:0] LeadBadMax = 8'hC1;
  localparam logic [ByteW-1:0] Lead3Min   = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Min   = 8'hF0;
  localparam logic [ByteW-1:0] LeadMax    = 8'hF4;

  // Surrogate range
  localparam logic [CpW-1:0] SurrLo = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi = 21'h00DFFF;

  // One decoded result word
  typedef struct packed {
    logic [CpW-1:0] code_point;
    status_e        status;
    logic           end_of_string;
  } result_t;

endpackage

>>> rtl/utf8_stream_decoder_top.sv
// Top level of the UTF-8 stream decoder.
//
// Input channel: in_valid_i / in_stall_o carry one byte word (data_byte_i,
// last_of_string_i flags the final byte of a string). Output channel:
// out_valid_o / out_stall_i carry one result word (code_point_o, status_o,
// end_of_string_o). A word moves when valid is high and stall is low.
// Lead and middle bytes of a multi-byte character give no result; the byte
// that completes it, any error, or a string cut mid-sequence gives one.
// Each result passes from the input register through the decode logic into the
// output register; a receiver stall can hold it in between. Throughput: one byte
// per cycle while not stalled, set by the single decode step between the two registers.
// When the receiver stalls, the result is held and the byte behind it
// waits in the input register; a byte that gives no result still moves on.
// Reset clears both valid flags and the decode state (expecting a lead).
`timescale 1ns / 1ps
module utf8_stream_decoder_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [u8d_pkg::ByteW-1:0] data_byte_i,
  input  logic                      last_of_string_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [u8d_pkg::CpW-1:0]   code_point_o,
  output logic [2:0]                status_o,
  output logic                      end_of_string_o
);

  logic                      ir_vld;
  logic [u8d_pkg::ByteW-1:0] ir_byte;
  logic                      ir_last;
  logic                      res_vld;
  u8d_pkg::result_t          res;
  logic                      out_free;
  logic                      advance;

  // Held byte moves on unless its result finds the output slot busy
  assign advance = ir_vld && (!res_vld || out_free);

  u8d_in_reg u_in_reg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .data_byte_i      (data_byte_i),
    .last_of_string_i (last_of_string_i),
    .advance_i        (advance),
    .in_stall_o       (in_stall_o),
    .vld_o            (ir_vld),
    .byte_o           (ir_byte),
    .last_o           (ir_last)
  );

  u8d_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (ir_byte),
    .last_i    (ir_last),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  u8d_out_reg u_out_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (advance && res_vld),
    .res_i           (res),
    .out_stall_i     (out_stall_i),
    .free_o          (out_free),
    .out_valid_o     (out_valid_o),
    .code_point_o    (code_point_o),
    .status_o        (status_o),
    .end_of_string_o (end_of_string_o)
  );

endmodule

>>> rtl/u8d_in_reg.sv
// Input register: holds one byte word until the decoder consumes it.
`timescale 1ns / 1ps
module u8d_in_reg (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic [u8d_pkg::ByteW-1:0] data_byte_i,
  input  logic                    last_of_string_i,
  input  logic                    advance_i,
  output logic                    in_stall_o,
  output logic                    vld_o,
  output logic [u8d_pkg::ByteW-1:0] byte_o,
  output logic                    last_o
);

  logic                      vld_q, vld_d;
  logic [u8d_pkg::ByteW-1:0] byte_q;
  logic                      last_q;
  logic                      accept;

  // Stall only while a held word cannot move on
  assign in_stall_o = vld_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign vld_d      = accept || (vld_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= data_byte_i;
      last_q <= last_of_string_i;
    end
  end

  assign vld_o  = vld_q;
  assign byte_o = byte_q;
  assign last_o = last_q;

endmodule

>>> rtl/u8d_decode.sv
// Decoder: sequence state and per-byte decode logic.
`timescale 1ns / 1ps
module u8d_decode (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      advance_i,
  input  logic [u8d_pkg::ByteW-1:0] byte_i,
  input  logic                      last_i,
  output logic                      res_vld_o,
  output u8d_pkg::result_t          res_o
);

  logic [u8d_pkg::CpW-1:0] partial_q, partial_d;
  logic [1:0]              left_q, left_d;
  logic [u8d_pkg::CpW-1:0] next_val;
  logic                    cont_ok;
  logic                    is_surr;

  assign cont_ok  = (byte_i[7:6] == 2'b10);
  assign next_val = {partial_q[u8d_pkg::CpW-7:0], byte_i[5:0]};
  assign is_surr  = (next_val >= u8d_pkg::SurrLo) && (next_val <= u8d_pkg::SurrHi);

  // Next state and result for the byte in the input register
  always_comb begin
    partial_d               = partial_q;
    left_d                  = left_q;
    res_vld_o               = 1'b0;
    res_o.code_point        = '0;
    res_o.status            = u8d_pkg::ST_OK;
    res_o.end_of_string     = last_i;
    if (left_q == 2'd0) begin
      if (!byte_i[7]) begin
        res_vld_o        = 1'b1;
        res_o.code_point = {{(u8d_pkg::CpW-u8d_pkg::ByteW){1'b0}}, byte_i};
      end else if (byte_i <= u8d_pkg::LeadBadMax || byte_i > u8d_pkg::LeadMax) begin
        res_vld_o    = 1'b1;
        res_o.status = u8d_pkg::ST_BAD_LEAD;
      end else begin
        if (byte_i < u8d_pkg::Lead3Min) begin
          partial_d = {16'd0, byte_i[4:0]};
          left_d    = 2'd1;
        end else if (byte_i < u8d_pkg::Lead4Min) begin
          partial_d = {17'd0, byte_i[3:0]};
          left_d    = 2'd2;
        end else begin
          partial_d = {18'd0, byte_i[2:0]};
          left_d    = 2'd3;
        end
        if (last_i) begin
          res_vld_o    = 1'b1;
          res_o.status = u8d_pkg::ST_TRUNC;
        end
      end
    end else if (!cont_ok) begin
      res_vld_o    = 1'b1;
      res_o.status = u8d_pkg::ST_BAD_CONT;
    end else begin
      partial_d = next_val;
      left_d    = left_q - 2'd1;
      if (left_q == 2'd1) begin
        res_vld_o = 1'b1;
        if (is_surr) begin
          res_o.status = u8d_pkg::ST_SURROGATE;
        end else begin
          res_o.code_point = next_val;
        end
      end else if (last_i) begin
        res_vld_o    = 1'b1;
        res_o.status = u8d_pkg::ST_TRUNC;
      end
    end
    // Any result ends the sequence
    if (res_vld_o) begin
      partial_d = '0;
      left_d    = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      left_q    <= 2'd0;
    end else if (advance_i) begin
      partial_q <= partial_d;
      left_q    <= left_d;
    end
  end

endmodule

>>> rtl/u8d_out_reg.sv
// Output register: holds one result word until the receiver takes it.
`timescale 1ns / 1ps
module u8d_out_reg (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  u8d_pkg::result_t        res_i,
  input  logic                    out_stall_i,
  output logic                    free_o,
  output logic                    out_valid_o,
  output logic [u8d_pkg::CpW-1:0] code_point_o,
  output logic [2:0]              status_o,
  output logic                    end_of_string_o
);

  logic             vld_q, vld_d;
  u8d_pkg::result_t res_q;

  // Slot is free when empty or being drained this cycle
  assign free_o = !vld_q || !out_stall_i;
  assign vld_d  = load_i || (vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o     = vld_q;
  assign code_point_o    = res_q.code_point;
  assign status_o        = res_q.status;
  assign end_of_string_o = res_q.end_of_string;

endmodule

>>> rtl/u8d_checker.sv
// Port checker for the UTF-8 stream decoder, bound to the top level.
`timescale 1ns / 1ps
module u8d_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [u8d_pkg::CpW-1:0] code_point_o,
  input logic [2:0]              status_o,
  input logic                    end_of_string_o
);

  // Stalled result word stays valid and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable(code_point_o) && $stable(status_o) && $stable(end_of_string_o))
    else $error("result word changed while stalled");

  // Error results carry a zero code point
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != u8d_pkg::ST_OK) |-> code_point_o == '0)
    else $error("nonzero code point on error result");

  // A good result never lands in the surrogate range
  a_no_surr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == u8d_pkg::ST_OK) |->
      !((code_point_o >= u8d_pkg::SurrLo) && (code_point_o <= u8d_pkg::SurrHi)))
    else $error("surrogate code point reported as ok");

  // Truncation only reported at the end of a string
  a_trunc_eos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == u8d_pkg::ST_TRUNC) |-> end_of_string_o)
    else $error("truncation without end of string");

endmodule

bind utf8_stream_decoder_top u8d_checker u_u8d_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .code_point_o    (code_point_o),
  .status_o        (status_o),
  .end_of_string_o (end_of_string_o)
);

>>> verif/tb_utf8_stream_decoder_top.sv
// Testbench for utf8_stream_decoder_top: directed and random byte strings, scoreboard check.
`timescale 1ns / 1ps
module tb_utf8_stream_decoder_top;

  // Receiver stall behaviors, switched at random
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_e;

  localparam int RandomWords = 600;

  logic                      clk_i            = 1'b0;
  logic                      rst_ni           = 1'b0;
  logic                      in_valid_i       = 1'b0;
  logic                      in_stall_o;
  logic [u8d_pkg::ByteW-1:0] data_byte_i      = '0;
  logic                      last_of_string_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i      = 1'b0;
  logic [u8d_pkg::CpW-1:0]   code_point_o;
  logic [2:0]                status_o;
  logic                      end_of_string_o;

  // Decoder state mirrored by the predictor
  logic [u8d_pkg::CpW-1:0] dec_partial = '0;
  logic [1:0]              dec_left    = '0;

  u8d_pkg::result_t decoded_q[$];
  int               error_count  = 0;
  int               burst_left   = 0;
  int               random_sent  = 0;
  int               stall_phase  = 0;
  int               cycle_count  = 0;
  stall_mode_e      stall_mode   = STALL_NONE;

  utf8_stream_decoder_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .last_of_string_i (last_of_string_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .code_point_o     (code_point_o),
    .status_o         (status_o),
    .end_of_string_o  (end_of_string_o)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predict the result of one byte; returns 1 when the byte yields a result word
  function automatic bit decode_byte(input logic [u8d_pkg::ByteW-1:0] b, input logic lst,
                                     output u8d_pkg::result_t r);
    bit hit;
    hit = 1'b1;
    r = '0;
    r.status = u8d_pkg::ST_OK;
    r.end_of_string = lst;
    if (dec_left == 2'd0) begin
      if (b < 8'h80) begin
        r.code_point = {13'd0, b};
      end else if (b <= u8d_pkg::LeadBadMax || b > u8d_pkg::LeadMax) begin
        r.status = u8d_pkg::ST_BAD_LEAD;
      end else begin
        if (b < u8d_pkg::Lead3Min) begin
          dec_partial = {16'd0, b[4:0]};
          dec_left = 2'd1;
        end else if (b < u8d_pkg::Lead4Min) begin
          dec_partial = {17'd0, b[3:0]};
          dec_left = 2'd2;
        end else begin
          dec_partial = {18'd0, b[2:0]};
          dec_left = 2'd3;
        end
        if (lst) r.status = u8d_pkg::ST_TRUNC;
        else hit = 1'b0;
      end
    end else if (b[7:6] != 2'b10) begin
      r.status = u8d_pkg::ST_BAD_CONT;
    end else begin
      dec_partial = {dec_partial[u8d_pkg::CpW-7:0], b[5:0]};
      dec_left = dec_left - 2'd1;
      if (dec_left == 2'd0) begin
        if (dec_partial >= u8d_pkg::SurrLo && dec_partial <= u8d_pkg::SurrHi) begin
          r.status = u8d_pkg::ST_SURROGATE;
        end else begin
          r.code_point = dec_partial;
        end
      end else if (lst) begin
        r.status = u8d_pkg::ST_TRUNC;
      end else begin
        hit = 1'b0;
      end
    end
    // every emitted word returns the decoder to idle
    if (hit) begin
      dec_partial = '0;
      dec_left = '0;
    end
    return hit;
  endfunction

  // Random lead byte for a sequence of len bytes; 3-byte leads favor 0xED (surrogates)
  function automatic logic [7:0] lead_byte(input int len);
    case (len)
      2:       return 8'($urandom_range(8'hC2, 8'hDF));
      3:       return ($urandom_range(0, 3) == 0) ? 8'hED : 8'($urandom_range(8'hE0, 8'hEF));
      default: return 8'($urandom_range(8'hF0, 8'hF4));
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  // Send one byte word; may idle between bursts, waits for acceptance, records prediction
  task automatic send_byte(input logic [u8d_pkg::ByteW-1:0] b, input logic lst);
    int gap;
    u8d_pkg::result_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 32);
    end
    in_valid_i       <= 1'b1;
    data_byte_i      <= b;
    last_of_string_i <= lst;
    do @(posedge clk_i); while (in_stall_o);
    if (decode_byte(b, lst, r)) decoded_q.push_back(r);
    burst_left--;
  endtask

  task automatic test_single_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  task automatic test_bad_leads();
    send_byte(8'h80, 1'b0);
    send_byte(8'hC1, 1'b0);
    send_byte(8'hF5, 1'b0);
    // bad lead on the final byte keeps its own status
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_multibyte();
    send_byte(8'hC2, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // largest 4-byte value, 0x13FFFF, is accepted
    send_byte(8'hF4, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  task automatic test_surrogate();
    send_byte(8'hED, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b0);
  endtask

  task automatic test_mid_sequence_errors();
    // ASCII byte inside a sequence is consumed as a bad continuation
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b0);
    // same error landing on the final byte
    send_byte(8'hE2, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  task automatic test_truncation();
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
  endtask

  // Strings of mostly well-formed characters, plus noise, broken and cut sequences
  task automatic test_random_strings();
    logic [7:0] str_q[$];
    int nchars;
    int kind;
    int len;
    int ncont;
    int b;
    bit cut;
    while (random_sent < RandomWords) begin
      str_q.delete();
      cut = 1'b0;
      nchars = $urandom_range(1, 6);
      for (int c = 0; c < nchars && !cut; c++) begin
        kind = $urandom_range(0, 99);
        if (kind < 65) begin
          len = $urandom_range(1, 4);
          if (len == 1) begin
            str_q.push_back(8'($urandom_range(0, 127)));
          end else begin
            str_q.push_back(lead_byte(len));
            repeat (len - 1) str_q.push_back(cont_byte());
          end
        end else if (kind < 78) begin
          str_q.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 90) begin
          len = $urandom_range(2, 4);
          ncont = $urandom_range(0, len - 2);
          str_q.push_back(lead_byte(len));
          repeat (ncont) str_q.push_back(cont_byte());
          // any byte outside 10xxxxxx
          b = $urandom_range(0, 191);
          if (b >= 128) b += 64;
          str_q.push_back(8'(b));
        end else begin
          // string ends before the sequence completes
          len = $urandom_range(2, 4);
          ncont = $urandom_range(0, len - 2);
          str_q.push_back(lead_byte(len));
          repeat (ncont) str_q.push_back(cont_byte());
          cut = 1'b1;
        end
      end
      foreach (str_q[i]) send_byte(str_q[i], i == str_q.size() - 1);
      random_sent += str_q.size();
    end
  endtask

  // Receiver stall pattern
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (stall_phase == 0) begin
      stall_mode  <= stall_mode_e'($urandom_range(0, 3));
      stall_phase <= $urandom_range(16, 80);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      STALL_NONE:     out_stall_i <= 1'b0;
      STALL_RANDOM:   out_stall_i <= 1'($urandom_range(0, 1));
      STALL_PERIODIC: out_stall_i <= (cycle_count % 7) < 3;
      default:        out_stall_i <= $urandom_range(0, 3) != 0;
    endcase
  end

  // Result checker
  always @(posedge clk_i) begin
    u8d_pkg::result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: result word expected none actual cp %h status %0d eos %0b", $time,
                 code_point_o, status_o, end_of_string_o);
        error_count++;
      end else begin
        exp_r = decoded_q.pop_front();
        if (code_point_o !== exp_r.code_point) begin
          $display("%0t: code_point expected %h actual %h", $time,
                   exp_r.code_point, code_point_o);
          error_count++;
        end
        if (status_o !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status_o);
          error_count++;
        end
        if (end_of_string_o !== exp_r.end_of_string) begin
          $display("%0t: end_of_string expected %0b actual %0b", $time,
                   exp_r.end_of_string, end_of_string_o);
          error_count++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_bytes();
    test_bad_leads();
    test_multibyte();
    test_surrogate();
    test_mid_sequence_errors();
    test_truncation();
    test_random_strings();
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("utf8_stream_decoder_top: match");
    end else begin
      $display("utf8_stream_decoder_top: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("utf8_stream_decoder_top: mismatch");
    $finish;
  end

endmodule
